// ----- rtl/core/ecv_pkg.sv -----
package ecv_pkg;

    localparam int VEL_W   = 16;
    localparam int POS_W   = 16;
    localparam int N_W     = POS_W + 1;
    localparam int PR_W    = VEL_W + N_W;
    localparam int DOT_W   = PR_W + 1;
    localparam int SQ_W    = 2 * N_W;
    localparam int D_W     = SQ_W;
    localparam int PP_W    = DOT_W + N_W;
    localparam int NUM_W   = PP_W + 1;
    localparam int REM_W   = NUM_W + 1;
    localparam int QB      = VEL_W + 1;
    localparam int LANES   = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

    // velocity set of one particle pair
    typedef struct packed {
        logic signed [VEL_W-1:0] bvy;
        logic signed [VEL_W-1:0] bvx;
        logic signed [VEL_W-1:0] avy;
        logic signed [VEL_W-1:0] avx;
    } vel_set_t;

    // classified item handed from front to back
    typedef struct packed {
        logic                  coin;
        logic signed [N_W-1:0] nx;
        logic signed [N_W-1:0] ny;
        vel_set_t              vel;
    } pair_item_t;

    // side data carried along the back pipeline
    typedef struct packed {
        logic     coin;
        vel_set_t vel;
    } side_t;

endpackage

// ----- rtl/core/elastic_collision_velocity_2d.sv -----
// elastic collision of two equal-mass particles, velocities out
// a pair passes the front register, the queue, the arithmetic pipeline and the output register
// throughput: one particle pair per cycle while the output is not stalled, set by the
//   fully pipelined multiplier stages and the restoring divider
// reset: rst_n asynchronous active low clears all valid state; no clearing pass
module elastic_collision_velocity_2d (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_pos_x, a_pos_y, a_vel_x, a_vel_y, b_pos_x, b_pos_y, b_vel_x, b_vel_y
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // a_new_vel_x, a_new_vel_y, b_new_vel_x, b_new_vel_y
    output logic [63:0]  m_axis_tdata,
    // coincident, saturated
    output logic [1:0]   m_axis_tuser
);
    import ecv_pkg::*;

    logic       f_valid, f_ready;
    pair_item_t f_item;
    logic       q_valid, q_ready;
    pair_item_t q_item;

    // accept and classify
    ecv_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .item_valid    (f_valid),
        .item_ready    (f_ready),
        .item          (f_item)
    );

    // decoupling queue
    ecv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // arithmetic pipeline and output register
    ecv_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (q_valid),
        .item_ready    (q_ready),
        .item          (q_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ----- rtl/core/ecv_front.sv -----
module ecv_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // a_pos_x, a_pos_y, a_vel_x, a_vel_y, b_pos_x, b_pos_y, b_vel_x, b_vel_y
    input  logic [127:0]        s_axis_tdata,
    output logic                item_valid,
    input  logic                item_ready,
    output ecv_pkg::pair_item_t item
);
    import ecv_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    pair_item_t item_reg;
    pair_item_t item_next;
    logic signed [POS_W-1:0] apx, apy, bpx, bpy;

    assign s_axis_tready = !valid_reg || item_ready;
    assign apx = s_axis_tdata[15:0];
    assign apy = s_axis_tdata[31:16];
    assign bpx = s_axis_tdata[79:64];
    assign bpy = s_axis_tdata[95:80];

    // form the offset vector and flag coincident positions
    always_comb
    begin
        item_next.nx      = N_W'(apx) - N_W'(bpx);
        item_next.ny      = N_W'(apy) - N_W'(bpy);
        item_next.coin    = (apx == bpx) && (apy == bpy);
        item_next.vel.avx = s_axis_tdata[47:32];
        item_next.vel.avy = s_axis_tdata[63:48];
        item_next.vel.bvx = s_axis_tdata[111:96];
        item_next.vel.bvy = s_axis_tdata[127:112];
        valid_next        = s_axis_tvalid || (valid_reg && !item_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/core/ecv_queue.sv -----
module ecv_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ecv_pkg::pair_item_t in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output ecv_pkg::pair_item_t out_item
);
    import ecv_pkg::*;

    pair_item_t mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic push, pop;

    assign in_ready  = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0 && count_reg != QCNT_W'(QUEUE_DEPTH)) |->
        (QPTR_W'(wr_ptr_reg - rd_ptr_reg) == QPTR_W'(count_reg)))
        else $error("queue pointers disagree with count");
`endif

endmodule

// ----- rtl/core/ecv_back.sv -----
module ecv_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  ecv_pkg::pair_item_t item,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // a_new_vel_x, a_new_vel_y, b_new_vel_x, b_new_vel_y
    output logic [63:0]         m_axis_tdata,
    // coincident, saturated
    output logic [1:0]          m_axis_tuser
);
    import ecv_pkg::*;

    localparam int PRE = 6;            // stages before the divider
    localparam int NST = PRE + QB;     // valid stages ahead of the output register

    logic en;
    logic [NST-1:0] vld_reg;
    side_t side_reg [NST];

    // stage 1: terms of the dot and cross products, squared offset components
    logic signed [PR_W-1:0] pr_reg [8];
    logic signed [SQ_W-1:0] sqx_reg, sqy_reg;
    logic signed [N_W-1:0]  nx1_reg, ny1_reg, nx2_reg, ny2_reg;
    // stage 2: components along n and t, squared distance
    logic signed [DOT_W-1:0] an_reg, at_reg, bn_reg, bt_reg;
    logic [D_W-1:0] d_reg [PRE-2];
    // stage 3: second products
    logic signed [PP_W-1:0] pp_reg [8];
    // stage 4: numerators
    logic signed [NUM_W-1:0] num_reg [LANES];
    // stage 5: sign and magnitude
    logic [LANES-1:0] neg_reg [NST-4];
    logic [NUM_W-1:0] mag_reg [LANES];
    // stage 6 onward: rounded dividend, overflow, restoring division
    logic [REM_W-1:0] rem_reg [QB+1][LANES];
    logic [QB-1:0]    q_reg   [QB+1][LANES];
    logic [LANES-1:0] ovf_reg [QB+1];
    logic [D_W-1:0]   dd_reg  [QB+1];

    // output register
    logic        out_valid_reg;
    logic [63:0] out_data_reg, out_data_next;
    logic [1:0]  out_user_reg, out_user_next;

    assign en         = !out_valid_reg || m_axis_tready;
    assign item_ready = en;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[NST-2:0], item_valid};
            out_valid_reg <= vld_reg[NST-1];
        end
    end

    // side data shift line
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= '{coin: item.coin, vel: item.vel};
            for (int s = 1; s < NST; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // front arithmetic stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg[0] <= item.vel.avx * item.nx;
            pr_reg[1] <= item.vel.avy * item.ny;
            pr_reg[2] <= item.vel.avx * item.ny;
            pr_reg[3] <= item.vel.avy * item.nx;
            pr_reg[4] <= item.vel.bvx * item.nx;
            pr_reg[5] <= item.vel.bvy * item.ny;
            pr_reg[6] <= item.vel.bvx * item.ny;
            pr_reg[7] <= item.vel.bvy * item.nx;
            sqx_reg   <= item.nx * item.nx;
            sqy_reg   <= item.ny * item.ny;
            nx1_reg   <= item.nx;
            ny1_reg   <= item.ny;

            an_reg   <= {pr_reg[0][PR_W-1], pr_reg[0]} + {pr_reg[1][PR_W-1], pr_reg[1]};
            at_reg   <= {pr_reg[3][PR_W-1], pr_reg[3]} - {pr_reg[2][PR_W-1], pr_reg[2]};
            bn_reg   <= {pr_reg[4][PR_W-1], pr_reg[4]} + {pr_reg[5][PR_W-1], pr_reg[5]};
            bt_reg   <= {pr_reg[7][PR_W-1], pr_reg[7]} - {pr_reg[6][PR_W-1], pr_reg[6]};
            d_reg[0] <= $unsigned(sqx_reg) + $unsigned(sqy_reg);
            nx2_reg  <= nx1_reg;
            ny2_reg  <= ny1_reg;

            pp_reg[0] <= bn_reg * nx2_reg;
            pp_reg[1] <= at_reg * ny2_reg;
            pp_reg[2] <= bn_reg * ny2_reg;
            pp_reg[3] <= at_reg * nx2_reg;
            pp_reg[4] <= an_reg * nx2_reg;
            pp_reg[5] <= bt_reg * ny2_reg;
            pp_reg[6] <= an_reg * ny2_reg;
            pp_reg[7] <= bt_reg * nx2_reg;
            for (int s = 1; s < PRE - 2; s++)
            begin
                d_reg[s] <= d_reg[s-1];
            end

            num_reg[0] <= {pp_reg[0][PP_W-1], pp_reg[0]} - {pp_reg[1][PP_W-1], pp_reg[1]};
            num_reg[1] <= {pp_reg[2][PP_W-1], pp_reg[2]} + {pp_reg[3][PP_W-1], pp_reg[3]};
            num_reg[2] <= {pp_reg[4][PP_W-1], pp_reg[4]} - {pp_reg[5][PP_W-1], pp_reg[5]};
            num_reg[3] <= {pp_reg[6][PP_W-1], pp_reg[6]} + {pp_reg[7][PP_W-1], pp_reg[7]};

            for (int l = 0; l < LANES; l++)
            begin
                neg_reg[0][l] <= num_reg[l][NUM_W-1];
                mag_reg[l]    <= num_reg[l][NUM_W-1] ? NUM_W'(-num_reg[l])
                                                     : NUM_W'(num_reg[l]);
                // dividend 2|num| + d, rounds to nearest with ties away from zero
                rem_reg[0][l] <= {mag_reg[l], 1'b0} + REM_W'(d_reg[PRE-3]);
            end
            neg_reg[1] <= neg_reg[0];
            dd_reg[0]  <= d_reg[PRE-3];
        end
    end

    // overflow check: quotient needs more than the kept bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                ovf_reg[1][l] <= rem_reg[0][l] >= (REM_W'({dd_reg[0], 1'b0}) << QB);
                rem_reg[1][l] <= rem_reg[0][l];
                q_reg[1][l]   <= '0;
            end
            dd_reg[1]  <= dd_reg[0];
            neg_reg[2] <= neg_reg[1];
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 1; j < QB + 1; j++)
    begin : g_div
        if (j < QB)
        begin : g_stage
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    for (int l = 0; l < LANES; l++)
                    begin
                        if (rem_reg[j][l] >= (REM_W'({dd_reg[j], 1'b0}) << (QB - j)))
                        begin
                            rem_reg[j+1][l] <= rem_reg[j][l]
                                - (REM_W'({dd_reg[j], 1'b0}) << (QB - j));
                            q_reg[j+1][l]   <= q_reg[j][l] | (QB'(1) << (QB - j));
                        end
                        else
                        begin
                            rem_reg[j+1][l] <= rem_reg[j][l];
                            q_reg[j+1][l]   <= q_reg[j][l];
                        end
                    end
                    ovf_reg[j+1] <= ovf_reg[j];
                    dd_reg[j+1]  <= dd_reg[j];
                    neg_reg[j+2] <= neg_reg[j+1];
                end
            end
        end
    end

    // last quotient bit, sign, clamp and coincident bypass
    always_comb
    begin
        logic [QB-1:0] q;
        logic          sat;
        logic [VEL_W-1:0] r;
        side_t         sd;
        sd            = side_reg[NST-1];
        sat           = 1'b0;
        out_data_next = '0;
        for (int l = 0; l < LANES; l++)
        begin
            q = q_reg[QB][l];
            if (rem_reg[QB][l] >= REM_W'({dd_reg[QB], 1'b0}))
            begin
                q = q | QB'(1);
            end
            if (neg_reg[QB+1][l])
            begin
                if (ovf_reg[QB][l] || q > {1'b0, VEL_MAX} + 1'b1)
                begin
                    r   = VEL_MIN;
                    sat = 1'b1;
                end
                else
                begin
                    r = VEL_W'(-q);
                end
            end
            else
            begin
                if (ovf_reg[QB][l] || q > {1'b0, VEL_MAX})
                begin
                    r   = VEL_MAX;
                    sat = 1'b1;
                end
                else
                begin
                    r = VEL_W'(q);
                end
            end
            out_data_next[l*VEL_W +: VEL_W] = r;
        end
        if (sd.coin)
        begin
            out_data_next = sd.vel;
            sat           = 1'b0;
        end
        out_user_next = {sat, sd.coin};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

`ifndef NO_ASSERTIONS
    a_coin_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> !m_axis_tuser[1])
        else $error("coincident result flagged as saturated");
    a_out_from_chain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(vld_reg[NST-1]))
        else $error("result appeared without a pipeline item");
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import ecv_pkg::*;

    localparam int LATENCY = 25;

    typedef struct packed {
        logic signed [15:0] bvy;
        logic signed [15:0] bvx;
        logic signed [15:0] bpy;
        logic signed [15:0] bpx;
        logic signed [15:0] avy;
        logic signed [15:0] avx;
        logic signed [15:0] apy;
        logic signed [15:0] apx;
    } pair_in_t;

    typedef struct packed {
        logic               sat;
        logic               coin;
        logic signed [15:0] bvy;
        logic signed [15:0] bvx;
        logic signed [15:0] avy;
        logic signed [15:0] avx;
    } new_vel_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    new_vel_t     expected_vel_q[$];
    int           error_count;
    int           sent_count;
    int           checked_count;
    int           coin_count;
    int           sat_count;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_off_cycles;

    elastic_collision_velocity_2d uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // rounded quotient, ties away from zero; den > 0
    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        begin
            mag = (num < 0) ? -num : num;
            q = (2 * mag + den) / (2 * den);
            return (num < 0) ? -q : q;
        end
    endfunction

    function automatic logic signed [15:0] clamp_vel(longint v, ref logic sat);
        begin
            if (v > 32767)
            begin
                sat = 1'b1;
                return 16'sh7fff;
            end
            if (v < -32768)
            begin
                sat = 1'b1;
                return 16'sh8000;
            end
            return v[15:0];
        end
    endfunction

    // post-collision velocities of one pair
    function automatic new_vel_t collide(pair_in_t p);
        new_vel_t r;
        longint nx, ny, d, an, at, bn, bt;
        logic sat;
        begin
            nx = longint'(p.apx) - longint'(p.bpx);
            ny = longint'(p.apy) - longint'(p.bpy);
            d = nx * nx + ny * ny;
            sat = 1'b0;
            if (d == 0)
            begin
                r.avx = p.avx;
                r.avy = p.avy;
                r.bvx = p.bvx;
                r.bvy = p.bvy;
                r.coin = 1'b1;
            end
            else
            begin
                an = p.avx * nx + p.avy * ny;
                at = -p.avx * ny + p.avy * nx;
                bn = p.bvx * nx + p.bvy * ny;
                bt = -p.bvx * ny + p.bvy * nx;
                r.avx = clamp_vel(round_div(bn * nx - at * ny, d), sat);
                r.avy = clamp_vel(round_div(bn * ny + at * nx, d), sat);
                r.bvx = clamp_vel(round_div(an * nx - bt * ny, d), sat);
                r.bvy = clamp_vel(round_div(an * ny + bt * nx, d), sat);
                r.coin = 1'b0;
            end
            r.sat = sat;
            return r;
        end
    endfunction

    // send one pair, waiting for the transfer; valid stays up for the next pair
    task automatic send_pair(pair_in_t p);
        begin
            while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= p;
            @(posedge clk);
            while (!s_axis_tready)
            begin
                @(posedge clk);
            end
            expected_vel_q = {expected_vel_q, collide(p)};
            sent_count++;
            @(negedge clk);
        end
    endtask

    function automatic logic signed [15:0] rand_word(int kind);
        begin
            case (kind)
                0: return 16'sh7fff;
                1: return 16'sh8000;
                2: return 16'($urandom_range(32, 0) - 16);
                default: return 16'($urandom());
            endcase
        end
    endfunction

    function automatic pair_in_t rand_pair();
        pair_in_t p;
        begin
            p = {$urandom(), $urandom(), $urandom(), $urandom()};
            case ($urandom_range(9))
                0:
                begin
                    p.bpx = p.apx;
                    p.bpy = p.apy;
                end
                1, 2:
                begin
                    // close positions, large quotients likely
                    p.bpx = p.apx + rand_word(2);
                    p.bpy = p.apy + rand_word(2);
                end
                3:
                begin
                    p.apx = rand_word($urandom_range(3));
                    p.bvy = rand_word($urandom_range(3));
                    p.avx = rand_word($urandom_range(3));
                end
                default: ;
            endcase
            return p;
        end
    endfunction

    // result checking; the receiver stall is driven in the next block
    always @(posedge clk)
    begin
        new_vel_t got;
        new_vel_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser[1], m_axis_tuser[0], m_axis_tdata};
            if (expected_vel_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end
            else
            begin
                want = expected_vel_q.pop_front();
                checked_count++;
                if (want.coin)
                    coin_count++;
                if (want.sat)
                    sat_count++;
                if (got !== want)
                    $display("%0t: mismatch expected avx %h avy %h bvx %h bvy %h coin %b sat %b",
                        $time, want.avx, want.avy, want.bvx, want.bvy, want.coin, want.sat,
                        " actual avx %h avy %h bvx %h bvy %h coin %b sat %b",
                        got.avx, got.avy, got.bvx, got.bvy, got.coin, got.sat);
                if (got !== want)
                    error_count++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_off_cycles--;
        end
        else
            m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    task automatic wait_drained();
        begin
            s_axis_tvalid <= 1'b0;
            while (expected_vel_q.size() != 0)
                @(negedge clk);
        end
    endtask

    task automatic test_directed();
        pair_in_t p;
        begin
            // coincident, including at the extremes
            p = '0;
            p.avx = 16'sh7fff; p.avy = 16'sh8000; p.bvx = 16'sh1234; p.bvy = -16'sd5;
            send_pair(p);
            p.apx = 16'sh8000; p.apy = 16'sh7fff; p.bpx = 16'sh8000; p.bpy = 16'sh7fff;
            send_pair(p);
            // head-on along x: velocities swap
            p = '0;
            p.apx = 16'sd16; p.avx = -16'sd256; p.bvx = 16'sd512;
            send_pair(p);
            // along y, pure tangent motion
            p = '0;
            p.apy = -16'sd32; p.avx = 16'sd300; p.bvx = -16'sd77;
            send_pair(p);
            // widest separation
            p = '0;
            p.apx = 16'sh7fff; p.apy = 16'sh7fff; p.bpx = 16'sh8000; p.bpy = 16'sh8000;
            p.avx = 16'sh7fff; p.avy = 16'sh8000; p.bvx = 16'sh8000; p.bvy = 16'sh7fff;
            send_pair(p);
            // extreme velocities: diagonal offset, then a steeper one that saturates
            p = '0;
            p.apx = 16'sd1; p.apy = 16'sd1;
            p.avx = 16'sh7fff; p.avy = 16'sh7fff; p.bvx = 16'sh8000; p.bvy = 16'sh8000;
            send_pair(p);
            p.apy = 16'sd2; p.avy = 16'sh8000; p.bvy = 16'sh7fff;
            send_pair(p);
            // odd rounding at ties
            p = '0;
            p.apx = 16'sd1; p.apy = 16'sd1; p.avx = 16'sd1; p.bvy = -16'sd1;
            send_pair(p);
            p.avx = -16'sd3; p.bvx = 16'sd3;
            send_pair(p);
            // all ones and alternating bits
            p = '1;
            send_pair(p);
            p = {8{16'h5555}};
            send_pair(p);
            p = {8{16'haaaa}};
            send_pair(p);
            wait_drained();
        end
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        begin
            send_idle_pct = idle_pct;
            recv_stall_pct = stall_pct;
            repeat (count)
                send_pair(rand_pair());
        end
    endtask

    task automatic test_backpressure();
        begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
            hold_off_cycles = 200;
            repeat (60)
                send_pair(rand_pair());
            // pause until everything has come out
            wait_drained();
            repeat (20)
                send_pair(rand_pair());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        error_count = 0;
        sent_count = 0;
        checked_count = 0;
        coin_count = 0;
        sat_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(400, 0, 0);
        test_random(350, 58, 0);
        test_random(350, 0, 58);
        test_random(300, 25, 25);
        test_backpressure();
        test_random(50, 0, 0);

        recv_stall_pct = 0;
        wait_drained();
        repeat (LATENCY + 10)
            @(negedge clk);

        $display("pairs sent %0d, results checked %0d", sent_count, checked_count);
        $display("coincident cases %0d, saturated cases %0d", coin_count, sat_count);
        if (error_count == 0 && expected_vel_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("timeout");
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- elastic_collision_velocity_2d.f -----
rtl/core/ecv_pkg.sv
rtl/core/ecv_front.sv
rtl/core/ecv_queue.sv
rtl/core/ecv_back.sv
rtl/core/elastic_collision_velocity_2d.sv
sim/tb_top.sv
